/* hdl/hrp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hrp_pkg: shared types and codes of the hex record parser
// Request payload types, status codes and parser phases.
// ----------------------------------------------------------------------------
package hrp_pkg;

  localparam int DEF_MAX_DATA_BYTES = 16;
  localparam int HEADER_BYTES       = 12;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0a;

  localparam logic [3:0] ST_BYTE      = 4'd0;
  localparam logic [3:0] ST_DONE      = 4'd1;
  localparam logic [3:0] ST_BAD_HEX   = 4'd2;
  localparam logic [3:0] ST_NO_COLON  = 4'd3;
  localparam logic [3:0] ST_AFTER_END = 4'd4;
  localparam logic [3:0] ST_LENGTH    = 4'd5;
  localparam logic [3:0] ST_TYPE      = 4'd6;
  localparam logic [3:0] ST_CHECKSUM  = 4'd7;
  localparam logic [3:0] ST_NO_END    = 4'd8;

  typedef enum logic [1:0] {
    PH_LINE_START,
    PH_SKIP,
    PH_DIGITS,
    PH_TAIL
  } phase_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } char_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] status;
    logic       last;
  } rec_req_t;

endpackage
`default_nettype wire

/* hdl/hrp_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hrp_ram: generic single-write, single-read memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* hdl/hex_record_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hex_record_parser: hex record text to record blocks
// Parses text one character a request and emits a byte block per record.
// ----------------------------------------------------------------------------
// Usage:
//   char channel: one text character or an end-of-input mark per request.
//   rec channel: record blocks of 12 + MAX_DATA_BYTES bytes (length, offset,
//   type as little-endian words, then data padded with zeros), or one status
//   request with last set when an error or the end of input is reached.
//   Characters are taken one per cycle. A status is registered onto rec as
//   its character is taken. After the checksum character the block streams
//   its record one byte per cycle while rec is not stalled; the char
//   channel is held while that stream lasts, since the data bytes come
//   from the single read port of the data memory.
//   After a status the block takes and drops every character until reset.
//   Reset clears the parser to a line start and empties the rec register;
//   no memory clearing pass is needed. While rec is stalled the output register
//   holds its request and, until a status is given, the char channel is stalled as well.
// ----------------------------------------------------------------------------
module hex_record_parser #(
  parameter int MAX_DATA_BYTES = hrp_pkg::DEF_MAX_DATA_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              char_valid,
  output logic                   char_stall,
  input  wire hrp_pkg::char_req_t char_data,
  output logic                   rec_valid,
  input  wire logic              rec_stall,
  output hrp_pkg::rec_req_t      rec_data
);

  import hrp_pkg::*;

  localparam int BLOCK_BYTES = HEADER_BYTES + MAX_DATA_BYTES;
  localparam int AW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
  localparam int KW = $clog2(BLOCK_BYTES);
  localparam int BW = $clog2(MAX_DATA_BYTES + 6);
  localparam int CW = ((BW > 8) ? BW : 8) + 1;
  localparam int EW = ((KW > 8) ? KW : 8) + 1;
  localparam logic [7:0]    LEN_MAX  = 8'(MAX_DATA_BYTES);
  localparam logic [KW-1:0] K_LAST   = KW'(BLOCK_BYTES - 1);
  localparam logic [KW-1:0] K_HEADER = KW'(HEADER_BYTES);

  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  phase_t          phase, phase_next;
  logic            halted;
  logic            eof_rec_seen;
  logic            emitting;
  logic [KW-1:0]   k;
  logic            nib;
  logic [3:0]      high_nibble;
  logic [BW-1:0]   byte_idx;
  logic [7:0]      byte_sum;
  logic [7:0]      record_length;
  logic [15:0]     record_offset;
  logic            record_type;

  logic            acc;
  logic            slot_free;
  logic [7:0]      c;
  logic            eoi;
  logic [4:0]      hv;
  logic [7:0]      byte_val;
  logic [7:0]      sum_next;
  logic [CW-1:0]   idx_ext;
  logic            in_data_bytes;
  logic            give_st;
  logic [3:0]      st_code;
  logic            start_emit;
  logic            wr_en;
  logic            emit_load;
  logic [7:0]      emit_byte;
  logic [7:0]      rd_data;
  logic [KW-1:0]   rd_k;
  logic [KW-1:0]   rd_off;
  logic [EW-1:0]   k_ext;
  logic [AW-1:0]   wr_addr;
  logic [CW-1:0]   data_off;

  assign c         = char_data.char_in;
  assign eoi       = char_data.end_of_input;
  assign slot_free = !rec_valid || !rec_stall;
  assign char_stall = !halted && (emitting || !slot_free);
  assign acc       = char_valid && !char_stall;
  assign emit_load = emitting && slot_free;

  assign hv       = hex_dec(c);
  assign byte_val = {high_nibble, hv[3:0]};
  assign sum_next = byte_sum + byte_val;
  assign idx_ext  = CW'(byte_idx);
  assign data_off = idx_ext - CW'(4);
  assign in_data_bytes = (idx_ext >= CW'(4)) && (data_off < CW'(record_length));
  assign wr_addr  = data_off[AW-1:0];

  assign rd_k   = emit_load ? (k + KW'(1)) : k;
  assign rd_off = rd_k - K_HEADER;
  assign k_ext  = EW'(k);

  hrp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_DATA_BYTES),
    .AW    (AW)
  ) u_data (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (byte_val),
    .rd_addr (rd_off[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    give_st    = 1'b0;
    st_code    = ST_BYTE;
    start_emit = 1'b0;
    wr_en      = 1'b0;
    if (acc && !halted) begin
      if (eoi) begin
        give_st = 1'b1;
        if (phase == PH_DIGITS) begin
          st_code = ST_BAD_HEX;
        end else begin
          st_code = eof_rec_seen ? ST_DONE : ST_NO_END;
        end
      end else begin
        unique case (phase)
          PH_LINE_START: begin
            if (c != CH_HASH && c != CH_LF) begin
              if (c != CH_COLON) begin
                give_st = 1'b1;
                st_code = ST_NO_COLON;
              end else if (eof_rec_seen) begin
                give_st = 1'b1;
                st_code = ST_AFTER_END;
              end
            end
          end
          PH_SKIP, PH_TAIL: begin
          end
          PH_DIGITS: begin
            if (!hv[4]) begin
              give_st = 1'b1;
              st_code = ST_BAD_HEX;
            end else if (nib) begin
              if (byte_idx == BW'(3)) begin
                if (record_length > LEN_MAX) begin
                  give_st = 1'b1;
                  st_code = ST_LENGTH;
                end else if (byte_val > 8'd1) begin
                  give_st = 1'b1;
                  st_code = ST_TYPE;
                end
              end else if (idx_ext >= CW'(4)) begin
                if (in_data_bytes) begin
                  wr_en = 1'b1;
                end else if (sum_next != 8'd0) begin
                  give_st = 1'b1;
                  st_code = ST_CHECKSUM;
                end else begin
                  start_emit = 1'b1;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    phase_next = phase;
    if (acc && !halted && !eoi) begin
      unique case (phase)
        PH_LINE_START: begin
          if (c == CH_HASH) begin
            phase_next = PH_SKIP;
          end else if (c == CH_COLON && !eof_rec_seen) begin
            phase_next = PH_DIGITS;
          end
        end
        PH_SKIP, PH_TAIL: begin
          if (c == CH_LF) begin
            phase_next = PH_LINE_START;
          end
        end
        PH_DIGITS: begin
          if (start_emit) begin
            phase_next = PH_TAIL;
          end
        end
        default: begin
          phase_next = PH_LINE_START;
        end
      endcase
    end
  end

  always_comb begin
    emit_byte = 8'd0;
    if (k == KW'(0)) begin
      emit_byte = record_length;
    end else if (k == KW'(4)) begin
      emit_byte = record_offset[7:0];
    end else if (k == KW'(5)) begin
      emit_byte = record_offset[15:8];
    end else if (k == KW'(8)) begin
      emit_byte = {7'd0, record_type};
    end else if (k_ext >= EW'(HEADER_BYTES)
                 && (k_ext - EW'(HEADER_BYTES)) < EW'(record_length)) begin
      emit_byte = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LINE_START;
      halted       <= 1'b0;
      eof_rec_seen <= 1'b0;
      emitting     <= 1'b0;
      rec_valid    <= 1'b0;
      k            <= '0;
    end else begin
      phase <= phase_next;
      if (give_st) begin
        halted <= 1'b1;
      end
      if (start_emit) begin
        emitting     <= 1'b1;
        k            <= '0;
        eof_rec_seen <= record_type;
      end else if (emit_load) begin
        k <= k + KW'(1);
        if (k == K_LAST) begin
          emitting <= 1'b0;
        end
      end
      if (emit_load || give_st) begin
        rec_valid <= 1'b1;
      end else if (!rec_stall) begin
        rec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      rec_data <= '{out_byte: emit_byte, status: ST_BYTE, last: (k == K_LAST)};
    end else if (give_st) begin
      rec_data <= '{out_byte: 8'd0, status: st_code, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !halted && !eoi) begin
      if (phase == PH_LINE_START && c == CH_COLON) begin
        nib      <= 1'b0;
        byte_idx <= '0;
        byte_sum <= 8'd0;
      end else if (phase == PH_DIGITS && hv[4]) begin
        if (!nib) begin
          high_nibble <= hv[3:0];
          nib         <= 1'b1;
        end else begin
          nib      <= 1'b0;
          byte_idx <= byte_idx + BW'(1);
          byte_sum <= sum_next;
          if (byte_idx == BW'(0)) begin
            record_length <= byte_val;
          end else if (byte_idx == BW'(1)) begin
            record_offset[15:8] <= byte_val;
          end else if (byte_idx == BW'(2)) begin
            record_offset[7:0] <= byte_val;
          end else if (byte_idx == BW'(3)) begin
            record_type <= byte_val[0];
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hex_record_parser
// Feeds the parser a character stream of empty lines, comments and records,
// then one randomly chosen ending and characters that follow the ending, and checks
// every rec request against a cycle-free parser model kept in the bench. The
// sender works in bursts, the receiver stalls on its own rotating pattern.
// ----------------------------------------------------------------------------
module testbench;
  import hrp_pkg::*;

  localparam int BLOCK_LEN    = HEADER_BYTES + DEF_MAX_DATA_BYTES;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 2 * BLOCK_LEN + 8;
  localparam int RANDOM_CHARS = 420;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      char_valid = 1'b0;
  logic      char_stall;
  char_req_t char_data = '0;
  logic      rec_valid;
  logic      rec_stall = 1'b0;
  rec_req_t  rec_data;

  hex_record_parser dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .rec_valid  (rec_valid),
    .rec_stall  (rec_stall),
    .rec_data   (rec_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser model state
  phase_t     phase_q = PH_LINE_START;
  int         digit_cnt = 0;
  logic [3:0] hi_nib = '0;
  logic [7:0] rec_len = '0;
  logic [15:0] rec_off = '0;
  logic       rec_type = 1'b0;
  logic [7:0] sum_acc = '0;
  logic [7:0] data_mem [DEF_MAX_DATA_BYTES] = '{default: '0};
  logic       seen_end = 1'b0;
  logic       halted_q = 1'b0;

  rec_req_t   pending_recs [$];
  rec_req_t   want_rec;

  int         fail_count = 0;
  int         chars_sent = 0;
  int         blocks_predicted = 0;
  int         bytes_checked = 0;
  int         burst_left = 0;
  int         cycle_count = 0;
  logic [3:0] ending = ST_DONE;
  logic [8:0] stall_tick = '0;

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h57);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h37);
    return -1;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CH_LF);
    return c;
  endfunction

  task automatic push_status(input logic [3:0] st);
    rec_req_t rr;
    rr.out_byte = '0;
    rr.status   = st;
    rr.last     = 1'b1;
    pending_recs.push_back(rr);
    halted_q = 1'b1;
  endtask

  task automatic predict_char(input char_req_t r);
    int         v;
    int         idx;
    logic [7:0] b;
    rec_req_t   rr;
    if (halted_q) return;
    if (r.end_of_input) begin
      if (phase_q == PH_DIGITS) push_status(ST_BAD_HEX);
      else push_status(seen_end ? ST_DONE : ST_NO_END);
      return;
    end
    case (phase_q)
      PH_LINE_START: begin
        if (r.char_in == CH_HASH) phase_q = PH_SKIP;
        else if (r.char_in == CH_LF) phase_q = PH_LINE_START;
        else if (r.char_in != CH_COLON) push_status(ST_NO_COLON);
        else if (seen_end) push_status(ST_AFTER_END);
        else begin
          phase_q   = PH_DIGITS;
          digit_cnt = 0;
          hi_nib    = '0;
          rec_len   = '0;
          rec_off   = '0;
          rec_type  = 1'b0;
          sum_acc   = '0;
          for (int i = 0; i < DEF_MAX_DATA_BYTES; i++) data_mem[i] = '0;
        end
        return;
      end
      PH_SKIP, PH_TAIL: begin
        if (r.char_in == CH_LF) phase_q = PH_LINE_START;
        return;
      end
      default: ;
    endcase
    v = nibble_of(r.char_in);
    if (v < 0) begin
      push_status(ST_BAD_HEX);
      return;
    end
    if (digit_cnt % 2 == 0) begin
      hi_nib = v[3:0];
      digit_cnt++;
      return;
    end
    b   = {hi_nib, v[3:0]};
    idx = digit_cnt / 2;
    digit_cnt++;
    sum_acc += b;
    if (idx == 0) rec_len = b;
    else if (idx == 1) rec_off[15:8] = b;
    else if (idx == 2) rec_off[7:0] = b;
    else if (idx == 3) begin
      if (rec_len > DEF_MAX_DATA_BYTES) push_status(ST_LENGTH);
      else if (b > 8'd1) push_status(ST_TYPE);
      else rec_type = b[0];
    end else if (idx - 4 < rec_len) begin
      data_mem[idx - 4] = b;
    end else if (sum_acc != 8'd0) begin
      push_status(ST_CHECKSUM);
    end else begin
      phase_q  = PH_TAIL;
      seen_end = rec_type;
      blocks_predicted++;
      for (int k = 0; k < BLOCK_LEN; k++) begin
        rr.out_byte = '0;
        if (k == 0) rr.out_byte = rec_len;
        else if (k == 4) rr.out_byte = rec_off[7:0];
        else if (k == 5) rr.out_byte = rec_off[15:8];
        else if (k == 8) rr.out_byte = {7'd0, rec_type};
        else if (k >= HEADER_BYTES) rr.out_byte = data_mem[k - HEADER_BYTES];
        rr.status = ST_BYTE;
        rr.last   = (k == BLOCK_LEN - 1);
        pending_recs.push_back(rr);
      end
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic eoi);
    int        gap;
    char_req_t r;
    r.char_in      = c;
    r.end_of_input = eoi;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        char_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    char_valid <= 1'b1;
    char_data  <= r;
    do @(posedge clk); while (char_stall);
    chars_sent++;
    predict_char(r);
  endtask

  task automatic send_comment(input int len);
    send_char(CH_HASH, 1'b0);
    repeat (len) send_char(text_char(), 1'b0);
    send_char(CH_LF, 1'b0);
  endtask

  // cut_digit >= 0 stops after that many hex digits
  task automatic send_record(input int len, input logic [15:0] off, input logic [7:0] typ,
                             input bit fill_rnd, input logic [7:0] fill,
                             input logic [7:0] sum_tweak, input int tail_len,
                             input int cut_digit, input bit end_line);
    logic [7:0] b;
    logic [7:0] sum;
    logic [3:0] nib;
    int         digit;
    sum   = '0;
    digit = 0;
    send_char(CH_COLON, 1'b0);
    for (int i = 0; i < len + 5; i++) begin
      if (i == 0) b = 8'(len);
      else if (i == 1) b = off[15:8];
      else if (i == 2) b = off[7:0];
      else if (i == 3) b = typ;
      else if (i < len + 4) b = fill_rnd ? 8'($urandom) : fill;
      else b = sum_tweak - sum;
      sum += b;
      for (int h = 1; h >= 0; h--) begin
        if (digit == cut_digit) return;
        nib = b[4*h +: 4];
        if (nib < 4'd10) send_char(8'h30 + nib, 1'b0);
        else send_char(($urandom_range(0, 1) ? 8'h37 : 8'h57) + nib, 1'b0);
        digit++;
      end
    end
    repeat (tail_len) send_char(text_char(), 1'b0);
    if (end_line) send_char(CH_LF, 1'b0);
  endtask

  task automatic test_directed_lines();
    send_char(CH_LF, 1'b0);
    send_char(CH_HASH, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(CH_LF, 1'b0);
    send_record(0, 16'hffff, 8'd0, 1'b0, 8'h00, 8'd0, 2, -1, 1'b1);
    send_record(DEF_MAX_DATA_BYTES, 16'h0000, 8'd0, 1'b0, 8'hff, 8'd0, 0, -1, 1'b1);
  endtask

  task automatic test_random_lines();
    int pick;
    int len;
    while (chars_sent < RANDOM_CHARS) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) send_char(CH_LF, 1'b0);
      else if (pick < 27) send_comment($urandom_range(0, 8));
      else begin
        len = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 4)
                                          : $urandom_range(5, DEF_MAX_DATA_BYTES);
        send_record(len, 16'($urandom), 8'd0, 1'b1, 8'h00, 8'd0,
                    ($urandom_range(0, 1) ? 0 : $urandom_range(1, 4)), -1, 1'b1);
      end
    end
  endtask

  task automatic test_final_status();
    int         len;
    int         place;
    logic [7:0] c;
    ending = 4'($urandom_range(ST_DONE, ST_NO_END));
    len    = $urandom_range(0, DEF_MAX_DATA_BYTES);
    place  = $urandom_range(0, 2);
    case (ending)
      ST_DONE, ST_NO_END: begin
        send_record(len, 16'($urandom), (ending == ST_DONE) ? 8'd1 : 8'd0, 1'b1, 8'h00,
                    8'd0, $urandom_range(0, 3), -1, place != 2);
        if (place == 1) begin
          send_char(CH_HASH, 1'b0);
          repeat ($urandom_range(0, 3)) send_char(text_char(), 1'b0);
        end
        send_char(8'($urandom), 1'b1);
      end
      ST_BAD_HEX: begin
        send_record(len, 16'($urandom), 8'd0, 1'b1, 8'h00, 8'd0, 0,
                    $urandom_range(0, 2 * (len + 5) - 1), 1'b0);
        case ($urandom_range(0, 3))
          0: send_char(8'($urandom), 1'b1);
          1: send_char(CH_LF, 1'b0);
          2: send_char(8'h0d, 1'b0);
          default: begin
            do c = 8'($urandom); while (nibble_of(c) >= 0);
            send_char(c, 1'b0);
          end
        endcase
      end
      ST_NO_COLON: begin
        do c = 8'($urandom); while (c == CH_HASH || c == CH_LF || c == CH_COLON);
        send_char(c, 1'b0);
      end
      ST_AFTER_END: begin
        send_record(len, 16'($urandom), 8'd1, 1'b1, 8'h00, 8'd0, 0, -1, 1'b1);
        if (place == 1) send_comment(2);
        if (place == 2) send_char(CH_LF, 1'b0);
        send_char(CH_COLON, 1'b0);
      end
      ST_LENGTH: begin
        send_record($urandom_range(DEF_MAX_DATA_BYTES + 1, 255), 16'($urandom),
                    8'($urandom), 1'b1, 8'h00, 8'd0, 0, 8, 1'b0);
      end
      ST_TYPE: begin
        send_record(len, 16'($urandom), 8'($urandom_range(2, 255)), 1'b1, 8'h00, 8'd0,
                    0, 8, 1'b0);
      end
      ST_CHECKSUM: begin
        send_record(len, 16'($urandom), 8'($urandom_range(0, 1)), 1'b1, 8'h00,
                    8'($urandom_range(1, 255)), 0, -1, 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic test_dropped_after_halt();
    repeat (12) send_char(8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic flag(input string what, input rec_req_t want, input rec_req_t got);
    if (fail_count < 10)
      $display("tb: %s: expected byte %h status %0d last %b, got byte %h status %0d last %b",
               what, want.out_byte, want.status, want.last,
               got.out_byte, got.status, got.last);
    fail_count++;
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    stall_tick <= stall_tick + 9'd1;
    case (stall_tick[8:7])
      2'd0:    rec_stall <= 1'b0;
      2'd1:    rec_stall <= ($urandom_range(0, 2) == 0);
      2'd2:    rec_stall <= (stall_tick[1:0] == 2'd3);
      default: rec_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rec_valid && !rec_stall) begin
      if (pending_recs.size() == 0) begin
        flag("unexpected request", '0, rec_data);
      end else begin
        want_rec = pending_recs.pop_front();
        if (want_rec.status == ST_BYTE) bytes_checked++;
        if (rec_data.out_byte !== want_rec.out_byte || rec_data.status !== want_rec.status ||
            rec_data.last !== want_rec.last)
          flag("mismatch", want_rec, rec_data);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: timeout with %0d requests outstanding", pending_recs.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_lines();
    test_random_lines();
    test_final_status();
    test_dropped_after_halt();
    char_valid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d characters sent, %0d record blocks and %0d bytes checked",
             chars_sent, blocks_predicted, bytes_checked);
    $display("tb: stream closed on status %0d, %0d mismatches", ending, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
